[sv/psc_pkg.sv]
// Package for the profile segment classifier: field widths, register
// indexes, feature class codes, result record type and shared helpers.
// No dependencies.
`default_nettype none

package psc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int Y_W         = 24;
	localparam int H_W         = 32;
	localparam int THICK_W     = 25;
	localparam int THR_W       = 23;
	localparam int GAP_W       = 8;
	localparam int NUM_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_OTHER_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLATE_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX   = 2'd2;

	localparam logic [THR_W-1:0] OTHER_THR_RST = 23'd400;
	localparam logic [THR_W-1:0] PLATE_THR_RST = 23'd200;
	localparam logic [GAP_W-1:0] GAP_MAX_RST   = 8'd4;

	typedef enum logic [1:0] {
		FT_OTHER = 2'd0,
		FT_PLATE = 2'd1,
		FT_FRAME = 2'd2
	} feat_type_t;

	typedef struct packed {
		feat_type_t                ftype;
		logic [NUM_W-1:0]          number;
		logic signed [H_W-1:0]     height;
		logic [H_W-1:0]            change;
		logic signed [THICK_W-1:0] thickness;
		logic                      last;
	} result_t;

	// |a - b| of two signed heights, exact over the full range
	function automatic logic [H_W-1:0] abs_diff(input logic signed [H_W-1:0] a,
		input logic signed [H_W-1:0] b);
		logic signed [H_W:0] d;
		d = {a[H_W-1], a} - {b[H_W-1], b};
		return d[H_W] ? H_W'(-d) : d[H_W-1:0];
	endfunction

	function automatic feat_type_t classify(input logic signed [THICK_W-1:0] thick,
		input logic [THR_W-1:0] other_thr, input logic [THR_W-1:0] plate_thr);
		feat_type_t t;
		if (thick > $signed({2'b00, other_thr})) begin
			t = FT_OTHER;
		end else if (thick >= $signed({2'b00, plate_thr})) begin
			t = FT_PLATE;
		end else begin
			t = FT_FRAME;
		end
		return t;
	endfunction

	function automatic logic signed [THICK_W-1:0] thickness(
		input logic signed [Y_W-1:0] first_y, input logic signed [Y_W-1:0] last_y);
		return {first_y[Y_W-1], first_y} - {last_y[Y_W-1], last_y};
	endfunction

endpackage

`default_nettype wire

[sv/profile_segment_classifier_core.sv]
// Profile segment classifier, top level: sample register, group tracker and
// classifier, four-entry result queue.  Depends on psc_pkg.
`default_nettype none

// Takes one profile sample per cycle (y, height, end_of_profile) and closes
// groups of nonzero height, bridging short zero gaps whose last y is nonzero.
// Each closed group gives one result beat with class (other / plate / frame),
// per-class running number, maximum height, height change against the
// previous feature of the same class, and thickness (first y minus last y).
// A sample is registered on acceptance and fully processed once the queue
// has room for two results: group update and both possible classifications
// are one combinational pass whose results are written into a four-entry
// result queue whose head drives the outputs. Throughput is one sample per cycle; a
// sample that closes two groups writes two queue entries in that cycle. The
// input stalls only while the queue holds three or more results, i.e. when the
// output side is backpressured. Counters and previous heights persist across
// profiles and clear only on reset. Configuration writes take effect at once
// and are meant to be done while no sample is in flight.
module profile_segment_classifier_core
	import psc_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,

	input  wire                       cfg_we,
	input  wire [CFG_IDX_W-1:0]       cfg_index,
	input  wire [THR_W-1:0]           cfg_data,

	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire signed [Y_W-1:0]      sample_y,
	input  wire signed [H_W-1:0]      sample_height,
	input  wire                       end_of_profile,

	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [1:0]                feature_type,
	output logic [NUM_W-1:0]          feature_number,
	output logic signed [H_W-1:0]     feature_height,
	output logic [H_W-1:0]            height_change,
	output logic signed [THICK_W-1:0] feature_thickness,
	output logic                      last_of_run
);

	// ---- configuration registers ----
	logic [THR_W-1:0] other_thr_q;
	logic [THR_W-1:0] plate_thr_q;
	logic [GAP_W-1:0] gap_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			other_thr_q <= OTHER_THR_RST;
			plate_thr_q <= PLATE_THR_RST;
			gap_max_q   <= GAP_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OTHER_THR: other_thr_q <= cfg_data;
				REG_PLATE_THR: plate_thr_q <= cfg_data;
				REG_GAP_MAX:   gap_max_q   <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- input sample register ----
	logic                  valid_s1;
	logic signed [Y_W-1:0] y_s1;
	logic signed [H_W-1:0] height_s1;
	logic                  eop_s1;
	logic                  s1_go;

	logic [QCNT_W-1:0]     count_q;

	// room for two results, checked on the registered count only
	assign s1_go    = valid_s1 && (count_q <= QCNT_W'(QDEPTH - 2));
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			y_s1      <= sample_y;
			height_s1 <= sample_height;
			eop_s1    <= end_of_profile;
		end
	end

	// ---- group tracking state ----
	logic                   open_q;
	logic                   in_gap_q;
	logic signed [Y_W-1:0]  first_y_q;
	logic signed [Y_W-1:0]  last_y_q;
	logic signed [H_W-1:0]  max_h_q;
	logic [GAP_W-1:0]       gap_len_q;
	logic signed [Y_W-1:0]  gap_last_y_q;
	logic signed [H_W-1:0]  prev_plate_q;
	logic signed [H_W-1:0]  prev_frame_q;
	logic [COUNT_WIDTH-1:0] plate_cnt_q;
	logic [COUNT_WIDTH-1:0] frame_cnt_q;

	// ---- single-pass update ----
	logic                   nz;
	logic [GAP_W-1:0]       gap_eff;
	logic                   emit_a;
	logic                   emit_b;
	logic                   gap_grow;
	logic                   open_mid;
	logic signed [Y_W-1:0]  first_mid;
	logic signed [Y_W-1:0]  last_mid;
	logic signed [H_W-1:0]  max_mid;

	logic signed [THICK_W-1:0] thick_a;
	logic signed [THICK_W-1:0] thick_b;
	feat_type_t             type_a;
	feat_type_t             type_b;
	logic [COUNT_WIDTH-1:0] plate_cnt_a;
	logic [COUNT_WIDTH-1:0] frame_cnt_a;
	logic signed [H_W-1:0]  prev_plate_a;
	logic signed [H_W-1:0]  prev_frame_a;
	logic [COUNT_WIDTH-1:0] plate_cnt_b;
	logic [COUNT_WIDTH-1:0] frame_cnt_b;
	logic signed [H_W-1:0]  prev_plate_b;
	logic signed [H_W-1:0]  prev_frame_b;
	result_t                res_a;
	result_t                res_b;
	result_t                push0;
	logic [1:0]             push_n;

	always_comb begin
		nz      = (height_s1 != '0);
		gap_eff = in_gap_q ? gap_len_q : '0;

		// first possible close: gap ending at y zero, or gap too long
		if (nz) begin
			emit_a = open_q && in_gap_q && (gap_last_y_q == '0);
		end else begin
			emit_a = open_q && (gap_eff >= gap_max_q);
		end
		gap_grow = !nz && open_q && !emit_a;

		// group as it stands after this sample, before end of profile
		if (nz) begin
			open_mid = 1'b1;
			if (open_q && !emit_a) begin
				first_mid = first_y_q;
				last_mid  = y_s1;
				max_mid   = (height_s1 > max_h_q) ? height_s1 : max_h_q;
			end else begin
				first_mid = y_s1;
				last_mid  = y_s1;
				max_mid   = height_s1;
			end
		end else begin
			open_mid  = open_q && !emit_a;
			first_mid = first_y_q;
			last_mid  = last_y_q;
			max_mid   = max_h_q;
		end
		emit_b = eop_s1 && open_mid;

		// classify the group closed first
		thick_a      = thickness(first_y_q, last_y_q);
		type_a       = classify(thick_a, other_thr_q, plate_thr_q);
		plate_cnt_a  = plate_cnt_q;
		frame_cnt_a  = frame_cnt_q;
		prev_plate_a = prev_plate_q;
		prev_frame_a = prev_frame_q;
		res_a.ftype     = type_a;
		res_a.height    = max_h_q;
		res_a.thickness = thick_a;
		res_a.last      = !emit_b;
		res_a.number    = '0;
		res_a.change    = '0;
		if (type_a == FT_PLATE) begin
			res_a.number = NUM_W'(COUNT_WIDTH'(plate_cnt_q + 1'b1));
			res_a.change = abs_diff(prev_plate_q, max_h_q);
			if (emit_a) begin
				plate_cnt_a  = COUNT_WIDTH'(plate_cnt_q + 1'b1);
				prev_plate_a = max_h_q;
			end
		end else if (type_a == FT_FRAME) begin
			res_a.number = NUM_W'(COUNT_WIDTH'(frame_cnt_q + 1'b1));
			res_a.change = abs_diff(prev_frame_q, max_h_q);
			if (emit_a) begin
				frame_cnt_a  = COUNT_WIDTH'(frame_cnt_q + 1'b1);
				prev_frame_a = max_h_q;
			end
		end

		// classify the group closed by end of profile, after the first
		thick_b      = thickness(first_mid, last_mid);
		type_b       = classify(thick_b, other_thr_q, plate_thr_q);
		plate_cnt_b  = plate_cnt_a;
		frame_cnt_b  = frame_cnt_a;
		prev_plate_b = prev_plate_a;
		prev_frame_b = prev_frame_a;
		res_b.ftype     = type_b;
		res_b.height    = max_mid;
		res_b.thickness = thick_b;
		res_b.last      = 1'b1;
		res_b.number    = '0;
		res_b.change    = '0;
		if (type_b == FT_PLATE) begin
			res_b.number = NUM_W'(COUNT_WIDTH'(plate_cnt_a + 1'b1));
			res_b.change = abs_diff(prev_plate_a, max_mid);
			if (emit_b) begin
				plate_cnt_b  = COUNT_WIDTH'(plate_cnt_a + 1'b1);
				prev_plate_b = max_mid;
			end
		end else if (type_b == FT_FRAME) begin
			res_b.number = NUM_W'(COUNT_WIDTH'(frame_cnt_a + 1'b1));
			res_b.change = abs_diff(prev_frame_a, max_mid);
			if (emit_b) begin
				frame_cnt_b  = COUNT_WIDTH'(frame_cnt_a + 1'b1);
				prev_frame_b = max_mid;
			end
		end

		push0  = emit_a ? res_a : res_b;
		push_n = {1'b0, emit_a} + {1'b0, emit_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			in_gap_q     <= 1'b0;
			first_y_q    <= '0;
			last_y_q     <= '0;
			max_h_q      <= '0;
			gap_len_q    <= '0;
			gap_last_y_q <= '0;
			prev_plate_q <= '0;
			prev_frame_q <= '0;
			plate_cnt_q  <= '0;
			frame_cnt_q  <= '0;
		end else if (s1_go) begin
			open_q       <= open_mid && !eop_s1;
			in_gap_q     <= gap_grow && !eop_s1;
			gap_len_q    <= (gap_grow && !eop_s1) ? GAP_W'(gap_eff + 1'b1) : '0;
			if (gap_grow) begin
				gap_last_y_q <= y_s1;
			end
			first_y_q    <= first_mid;
			last_y_q     <= last_mid;
			max_h_q      <= max_mid;
			prev_plate_q <= prev_plate_b;
			prev_frame_q <= prev_frame_b;
			plate_cnt_q  <= plate_cnt_b;
			frame_cnt_q  <= frame_cnt_b;
		end
	end

	// ---- result queue ----
	result_t           queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic              pop;
	logic [1:0]        push_go;
	result_t           head;

	assign pop     = out_valid && out_ready;
	assign push_go = s1_go ? push_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			count_q  <= QCNT_W'(count_q + QCNT_W'(push_go) - QCNT_W'(pop));
			wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(push_go));
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_go != 2'd0) begin
			queue_q[wr_ptr_q] <= push0;
		end
		if (push_go == 2'd2) begin
			queue_q[QPTR_W'(wr_ptr_q + 1'b1)] <= res_b;
		end
	end

	assign head              = queue_q[rd_ptr_q];
	assign out_valid         = (count_q != '0);
	assign feature_type      = head.ftype;
	assign feature_number    = head.number;
	assign feature_height    = head.height;
	assign height_change     = head.change;
	assign feature_thickness = head.thickness;
	assign last_of_run       = head.last;

	// ---- checks ----
	a_gap_needs_group: assert property (@(posedge clk) disable iff (!arst_n)
		in_gap_q |-> open_q)
		else $error("gap tracked with no open group");

	a_gap_len_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(gap_len_q != '0) |-> in_gap_q)
		else $error("gap length held outside a gap");

	a_eop_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && eop_s1) |=> (!open_q && !in_gap_q))
		else $error("group left open after end of profile");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

endmodule

`default_nettype wire
